FILE: rtl/core/duplicate_triangle_detector_core_defines.svh
// assertion macros for the duplicate triangle detector core
// used by duplicate_triangle_detector_core.sv, which must provide clk and rst_n
`ifndef DUPLICATE_TRIANGLE_DETECTOR_CORE_DEFINES_SVH
`define DUPLICATE_TRIANGLE_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define DTD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtd assertion failed");

// next-cycle implication
`define DTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtd assertion failed");

`endif

FILE: rtl/core/dtd_pkg.sv
// shared types and constants for the duplicate triangle detector
// no dependencies
`default_nettype none

package dtd_pkg;

    localparam int MAX_FACES  = 1024;
    localparam int INDEX_BITS = 24;
    localparam int ADDR_BITS  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int COUNT_BITS = $clog2(MAX_FACES + 1);
    localparam int KEY_BITS   = 3 * INDEX_BITS;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;

    typedef struct packed {
        index_t corner_a;
        index_t corner_b;
        index_t corner_c;
        logic   starts_mesh;
    } face_in_t;

    typedef struct packed {
        logic face_repeats;
        logic mesh_has_repeat;
        logic store_overflowed;
    } face_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic update;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic out_busy;
    } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/dtd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module dtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dtd_ctrl.sv
// sequencing state machine for the duplicate triangle detector
// depends on dtd_pkg
`default_nettype none

module dtd_ctrl
    import dtd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    face_valid,
    output logic         face_stall,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (face_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.hit || sts.scan_end)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        face_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                face_stall = 1'b0;
                cmd.accept = face_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dtd_datapath.sv
// key sort, triple store scan, sticky flags and output register
// depends on dtd_pkg and dtd_ram
`default_nettype none

module dtd_datapath
    import dtd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire face_in_t face,
    input  wire dp_cmd_t  cmd,
    output dp_sts_t       sts,
    output logic          result_valid,
    input  wire logic     result_stall,
    output face_out_t     result
);

    key_t      key_reg;
    key_t      key_next;
    count_t    count_reg;
    count_t    count_next;
    count_t    scan_idx_reg;
    count_t    scan_idx_next;
    logic      pend_reg;
    logic      pend_next;
    logic      hit_reg;
    logic      hit_next;
    logic      repeat_reg;
    logic      repeat_next;
    logic      overflow_reg;
    logic      overflow_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    face_out_t out_reg;
    face_out_t out_next;

    index_t    s0;
    index_t    s1;
    index_t    s2;
    index_t    tmp;
    key_t      rd_key;
    logic      match;
    logic      issue;
    logic      full;
    logic      wr_en;

    // three compare-swaps give ascending order
    always_comb
    begin
        s0 = face.corner_a;
        s1 = face.corner_b;
        s2 = face.corner_c;
        tmp = s0;
        if (s1 < s0)
        begin
            tmp = s0;
            s0  = s1;
            s1  = tmp;
        end
        if (s2 < s1)
        begin
            tmp = s1;
            s1  = s2;
            s2  = tmp;
        end
        if (s1 < s0)
        begin
            tmp = s0;
            s0  = s1;
            s1  = tmp;
        end
    end

    assign full  = (count_reg == COUNT_BITS'(MAX_FACES));
    assign match = pend_reg && (rd_key == key_reg);
    assign issue = cmd.scan && !match && (scan_idx_reg != count_reg);
    assign wr_en = cmd.update && !hit_reg && !full;

    assign sts.hit      = cmd.scan && match;
    assign sts.scan_end = cmd.scan && !match && (scan_idx_reg == count_reg);
    assign sts.out_busy = out_valid_reg && result_stall;

    dtd_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (MAX_FACES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_BITS-1:0]),
        .wdata (key_reg),
        .re    (issue),
        .raddr (scan_idx_reg[ADDR_BITS-1:0]),
        .rdata (rd_key)
    );

    always_comb
    begin
        key_next       = key_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        repeat_next    = repeat_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.accept)
        begin
            key_next      = {s0, s1, s2};
            scan_idx_next = '0;
            pend_next     = 1'b0;
            hit_next      = 1'b0;
            if (face.starts_mesh)
            begin
                count_next    = '0;
                repeat_next   = 1'b0;
                overflow_next = 1'b0;
            end
        end

        if (cmd.scan)
        begin
            pend_next = issue;
            if (issue)
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            if (match)
            begin
                hit_next = 1'b1;
            end
        end

        if (cmd.update)
        begin
            pend_next = 1'b0;
            if (hit_reg)
            begin
                repeat_next = 1'b1;
            end
            else if (!full)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next            = 1'b1;
            out_next.face_repeats     = hit_reg;
            out_next.mesh_has_repeat  = repeat_reg;
            out_next.store_overflowed = overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            repeat_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            repeat_reg    <= repeat_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/duplicate_triangle_detector_core.sv
// duplicate triangle detector: one face word in, one flag word out per face
// faces enter on the face channel (valid/stall), results leave on the result channel
// a face is sorted into ascending corner order and scanned against the stored
// distinct triples of the current mesh; starts_mesh empties the store first
// after accept a face passes through the scan, update and emit states before its
// result is valid; the scan reads the n stored triples (up to 1024, one ram read per
// cycle, stops on a hit); one face is in work at a time, so a new face is not taken
// before the last one is through; face_stall is high from accept until the result
// is placed in the output register
// a result waiting under result_stall does not block the next face; only
// the hand-off of the following result waits for the output register
// after reset the store is empty and both sticky flags are clear; no
// clearing pass is needed, so faces are taken from the first cycle
// depends on dtd_pkg, dtd_ctrl, dtd_datapath, dtd_ram
`default_nettype none
`include "duplicate_triangle_detector_core_defines.svh"

module duplicate_triangle_detector_core
    import dtd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     face_valid,
    output logic          face_stall,
    input  wire face_in_t face,
    output logic          result_valid,
    input  wire logic     result_stall,
    output face_out_t     result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    dtd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .face_valid (face_valid),
        .face_stall (face_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    dtd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .face         (face),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `DTD_ASSERT_NEXT(a_busy_after_accept, face_valid && !face_stall, face_stall)
    `DTD_ASSERT_IMP(a_repeat_sticky, result_valid && result.face_repeats, result.mesh_has_repeat)
    `DTD_ASSERT_IMP(a_emit_slot_free, cmd.emit, !sts.out_busy)
    `DTD_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, result_valid)

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for duplicate_triangle_detector_core: face words in, flag words out
// predicts the flags per face from its own sorted-triple store; depends on dtd_pkg and the core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dtd_pkg::*;

    localparam index_t TOP_INDEX = '1;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      face_valid = 1'b0;
    logic      face_stall;
    face_in_t  face = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    face_out_t result;

    duplicate_triangle_detector_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .face_valid   (face_valid),
        .face_stall   (face_stall),
        .face         (face),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    face_in_t    pending_faces[$];
    face_in_t    mesh_log[$];
    face_out_t   expected_flags[$];
    key_t        stored_keys[MAX_FACES];
    int          stored_n = 0;
    logic        mesh_repeat = 1'b0;
    logic        mesh_overflow = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int unsigned send_calm = 0;
    int unsigned recv_calm = 0;
    int          faces_accepted = 0;
    int          meshes = 0;
    int          results_checked = 0;
    int          repeat_results = 0;
    int          overflow_results = 0;
    int          errors = 0;

    function automatic face_out_t predict_flags(face_in_t f);
        index_t    lo;
        index_t    mid;
        index_t    hi;
        index_t    t;
        key_t      k;
        logic      hit;
        face_out_t r;
        if (f.starts_mesh)
        begin
            stored_n = 0;
            mesh_repeat = 1'b0;
            mesh_overflow = 1'b0;
        end
        lo = f.corner_a;
        mid = f.corner_b;
        hi = f.corner_c;
        if (mid < lo)
        begin
            t = lo; lo = mid; mid = t;
        end
        if (hi < mid)
        begin
            t = mid; mid = hi; hi = t;
        end
        if (mid < lo)
        begin
            t = lo; lo = mid; mid = t;
        end
        k = {lo, mid, hi};
        hit = 1'b0;
        for (int i = 0; i < stored_n; i++)
            if (stored_keys[i] == k)
                hit = 1'b1;
        if (hit)
            mesh_repeat = 1'b1;
        else if (stored_n < MAX_FACES)
        begin
            stored_keys[stored_n] = k;
            stored_n++;
        end
        else
            mesh_overflow = 1'b1;
        r.face_repeats = hit;
        r.mesh_has_repeat = mesh_repeat;
        r.store_overflowed = mesh_overflow;
        return r;
    endfunction

    function automatic int next_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        if (r < 4)
        begin
            send_calm = $urandom_range(60, 20);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    function automatic int next_stall();
        int unsigned r;
        r = $urandom_range(99);
        if (recv_calm > 0)
        begin
            recv_calm--;
            return 0;
        end
        if (r < 2)
        begin
            recv_calm = $urandom_range(500, 100);
            return 0;
        end
        if (r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic add_face(index_t a, index_t b, index_t c, logic start, logic mix);
        face_in_t f;
        f.starts_mesh = start;
        case (mix ? $urandom_range(5) : 0)
            0: begin f.corner_a = a; f.corner_b = b; f.corner_c = c; end
            1: begin f.corner_a = a; f.corner_b = c; f.corner_c = b; end
            2: begin f.corner_a = b; f.corner_b = a; f.corner_c = c; end
            3: begin f.corner_a = b; f.corner_b = c; f.corner_c = a; end
            4: begin f.corner_a = c; f.corner_b = a; f.corner_c = b; end
            default: begin f.corner_a = c; f.corner_b = b; f.corner_c = a; end
        endcase
        if (start)
            mesh_log.delete();
        mesh_log.insert(mesh_log.size(), f);
        pending_faces.insert(pending_faces.size(), f);
    endtask

    task automatic check_result(face_out_t got);
        face_out_t want;
        results_checked++;
        if (got.face_repeats)
            repeat_results++;
        if (got.store_overflowed)
            overflow_results++;
        if (expected_flags.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: result word with no face pending: %b", $realtime, got);
            return;
        end
        want = expected_flags.pop_front();
        if (got.face_repeats !== want.face_repeats
            || got.mesh_has_repeat !== want.mesh_has_repeat
            || got.store_overflowed !== want.store_overflowed)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: result %0d expected repeat=%b sticky=%b full=%b, got %b %b %b",
                         $realtime, results_checked, want.face_repeats,
                         want.mesh_has_repeat, want.store_overflowed, got.face_repeats,
                         got.mesh_has_repeat, got.store_overflowed);
        end
    endtask

    // face driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_valid <= 1'b0;
            face <= '0;
            gap_left <= 0;
        end
        else if (!(face_valid && face_stall))
        begin
            if (face_valid)
            begin
                expected_flags.insert(expected_flags.size(), predict_flags(face));
                faces_accepted++;
                if (face.starts_mesh)
                    meshes++;
            end
            if (gap_left > 0)
            begin
                face_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_faces.size() > 0)
            begin
                face <= pending_faces.pop_front();
                face_valid <= 1'b1;
                gap_left <= next_gap();
            end
            else
                face_valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left <= next_stall();
            end
        end
    end

    initial
    begin
        int          total_faces;
        int          mesh_left;
        int unsigned r;
        logic        start;
        face_in_t    pick;
        index_t      v[3];

        // directed: mesh opened by reset, extremes, all corner orders, degenerate faces
        add_face(0, 0, 0, 1'b0, 1'b0);
        add_face(TOP_INDEX, TOP_INDEX, TOP_INDEX, 1'b0, 1'b0);
        add_face(0, 0, 0, 1'b0, 1'b0);
        add_face(1, 2, 3, 1'b0, 1'b0);
        add_face(1, 3, 2, 1'b0, 1'b0);
        add_face(2, 1, 3, 1'b0, 1'b0);
        add_face(2, 3, 1, 1'b0, 1'b0);
        add_face(3, 1, 2, 1'b0, 1'b0);
        add_face(3, 2, 1, 1'b0, 1'b0);
        add_face(5, 5, 9, 1'b0, 1'b0);
        add_face(9, 5, 5, 1'b0, 1'b0);
        add_face(5, 9, 9, 1'b0, 1'b0);
        add_face(TOP_INDEX, 0, 1, 1'b0, 1'b0);
        add_face(1, TOP_INDEX, 0, 1'b0, 1'b0);
        add_face(1, 2, 3, 1'b1, 1'b0);
        add_face(3, 2, 1, 1'b0, 1'b0);
        add_face(TOP_INDEX, TOP_INDEX, TOP_INDEX, 1'b0, 1'b0);
        add_face(24'hAAAAAA, 24'h555555, TOP_INDEX, 1'b0, 1'b0);
        add_face(TOP_INDEX, 24'hAAAAAA, 24'h555555, 1'b0, 1'b0);
        add_face(24'h555555, TOP_INDEX, 24'hAAAAAA, 1'b1, 1'b0);
        add_face(24'h555555, TOP_INDEX, 24'hAAAAAA, 1'b1, 1'b0);

        // random meshes, mostly small, with repeats drawn from earlier faces
        mesh_left = 0;
        for (int i = 0; i < 560; i++)
        begin
            r = $urandom_range(99);
            start = (mesh_left == 0) || ($urandom_range(49) == 0);
            if (start)
                mesh_left = ($urandom_range(9) == 0) ? $urandom_range(120, 40)
                                                     : $urandom_range(25, 1);
            mesh_left--;
            if (r < 35 && mesh_log.size() > 0)
            begin
                pick = mesh_log[$urandom_range(mesh_log.size() - 1)];
                add_face(pick.corner_a, pick.corner_b, pick.corner_c, start, 1'b1);
            end
            else
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (r < 55)
                        v[j] = index_t'($urandom_range(7));
                    else if (r < 65)
                        case ($urandom_range(2))
                            0: v[j] = '0;
                            1: v[j] = TOP_INDEX;
                            default: v[j] = index_t'($urandom);
                        endcase
                    else
                        v[j] = index_t'($urandom);
                end
                add_face(v[0], v[1], v[2], start, 1'b1);
            end
        end
        total_faces = pending_faces.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (faces_accepted < total_faces || expected_flags.size() > 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);

        $display("faces sent %0d in %0d meshes, result words checked %0d", faces_accepted,
                 meshes, results_checked);
        $display("repeats flagged %0d, words with store full %0d, mismatches %0d",
                 repeat_results, overflow_results, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("timeout with %0d results outstanding", expected_flags.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/dtd_pkg.sv
rtl/core/dtd_ram.sv
rtl/core/dtd_ctrl.sv
rtl/core/dtd_datapath.sv
rtl/core/duplicate_triangle_detector_core.sv
bench/testbench.sv
